FILE: rtl/tam_pkg.sv
// Package for the three-axis moving average block.
// Fixed sample types, queue depth and the back-end state encoding. No dependencies.
package tam_pkg;

  localparam int SAMPLE_W = 16;
  localparam int AXES     = 3;
  localparam int COUNT_W  = 7;   // width of samples_in_window
  localparam int Q_DEPTH  = 2;   // front-to-back job queue

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  // element 0 is X, 1 is Y, 2 is Z
  typedef logic [AXES-1:0][SAMPLE_W-1:0] triple_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

FILE: rtl/tam_if.sv
// Valid/ready channel interfaces for sample input and mean output.
// Depends on tam_pkg for the payload types.
interface tam_in_if;
  logic               valid;
  logic               ready;
  tam_pkg::sample_t   sample_x;
  tam_pkg::sample_t   sample_y;
  tam_pkg::sample_t   sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tam_out_if;
  logic               valid;
  logic               ready;
  tam_pkg::sample_t   mean_x;
  tam_pkg::sample_t   mean_y;
  tam_pkg::sample_t   mean_z;
  tam_pkg::count_t    samples_in_window;

  modport source (output valid, output mean_x, output mean_y, output mean_z,
                  output samples_in_window, input ready);
  modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                  input samples_in_window, output ready);
endinterface

FILE: rtl/tam_queue.sv
// Short register queue carrying jobs from the front end to the back end.
// Depends on tam_pkg for its depth.
module tam_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int QAW = $clog2(tam_pkg::Q_DEPTH);

  logic [W-1:0] entry_r [tam_pkg::Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == (QAW+1)'(tam_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == QAW'(tam_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QAW'(tam_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/tam_front.sv
// Front end: accepts samples, assigns the ring slot and fill count for each.
// Depends on tam_pkg and tam_in_if.
module tam_front #(
  parameter int WINDOW = 100,
  parameter int PW     = 7,
  parameter int CW     = 7,
  parameter int JW     = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  tam_in_if.sink        in_ch,
  output logic          push,
  output logic [JW-1:0] push_data,
  input  logic          q_full
);

  logic [PW-1:0] ptr_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          live;
  logic          fire;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign push        = fire;

  // once the ring has wrapped the slot being replaced holds a real sample,
  // before that it has not been written since reset and is treated as zero
  assign live     = (fill_r == CW'(WINDOW));
  assign fill_nxt = live ? fill_r : fill_r + 1'b1;

  assign push_data = {in_ch.sample_z, in_ch.sample_y, in_ch.sample_x, ptr_r, fill_nxt, live};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (fire) begin
      ptr_r  <= (ptr_r == PW'(WINDOW-1)) ? '0 : ptr_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: rtl/tam_div.sv
// Three-lane restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividends, unsigned divisor shared by all lanes. Depends on tam_pkg.
module tam_div #(
  parameter int SW = 23,
  parameter int CW = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [tam_pkg::AXES-1:0][SW-1:0]     dividend,
  input  logic [CW-1:0]                        divisor,
  output logic                                 done,
  output tam_pkg::triple_t                     quot
);

  localparam int NW = $clog2(SW+1);

  logic [SW-1:0] mag_r [tam_pkg::AXES];
  logic [CW-1:0] rem_r [tam_pkg::AXES];
  logic          neg_r [tam_pkg::AXES];
  logic [CW-1:0] dsr_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [CW:0]   rem_sh [tam_pkg::AXES];
  logic [CW:0]   diff   [tam_pkg::AXES];
  logic [SW-1:0] qfin   [tam_pkg::AXES];

  always_comb begin
    for (int i = 0; i < tam_pkg::AXES; i++) begin
      rem_sh[i] = {rem_r[i], mag_r[i][SW-1]};
      diff[i]   = rem_sh[i] - {1'b0, dsr_r};
      qfin[i]   = neg_r[i] ? (~mag_r[i] + 1'b1) : mag_r[i];
      quot[i]   = qfin[i][tam_pkg::SAMPLE_W-1:0];
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(SW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      for (int i = 0; i < tam_pkg::AXES; i++) begin
        neg_r[i] <= dividend[i][SW-1];
        mag_r[i] <= dividend[i][SW-1] ? (~dividend[i] + 1'b1) : dividend[i];
        rem_r[i] <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < tam_pkg::AXES; i++) begin
        if (!diff[i][CW]) begin
          rem_r[i] <= diff[i][CW-1:0];
          mag_r[i] <= {mag_r[i][SW-2:0], 1'b1};
        end else begin
          rem_r[i] <= rem_sh[i][CW-1:0];
          mag_r[i] <= {mag_r[i][SW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: rtl/tam_back.sv
// Back end: ring memory, running sums and the result register.
// Depends on tam_pkg, tam_out_if and tam_div.
module tam_back #(
  parameter int WINDOW = 100,
  parameter int PW     = 7,
  parameter int CW     = 7,
  parameter int SW     = 23,
  parameter int JW     = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [JW-1:0] q_data,
  output logic          pop,
  tam_out_if.source     out_ch
);

  localparam int TW = tam_pkg::AXES * tam_pkg::SAMPLE_W;

  tam_pkg::back_state_t state_r, state_nxt;

  logic [JW-1:0]    job_r;
  tam_pkg::triple_t job_smp, rd_data_r, old_smp, mean_r, quot;
  logic [PW-1:0]    job_ptr;
  logic [CW-1:0]    job_fill;
  logic             job_live;

  logic [tam_pkg::AXES-1:0][SW-1:0] sum_r, sum_nxt;
  logic             wr_en, div_start, div_done;
  tam_pkg::count_t  count_r;

  logic [TW-1:0]    ring [WINDOW];

  assign job_live = job_r[0];
  assign job_fill = job_r[CW:1];
  assign job_ptr  = job_r[CW+PW:CW+1];
  assign job_smp  = job_r[JW-1:CW+PW+1];

  // slot not yet written since reset reads as zero
  assign old_smp = job_live ? rd_data_r : '0;

  always_comb begin
    for (int i = 0; i < tam_pkg::AXES; i++) begin
      sum_nxt[i] = sum_r[i] - SW'($signed(old_smp[i])) + SW'($signed(job_smp[i]));
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      tam_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = tam_pkg::BK_READ;
        end
      end
      tam_pkg::BK_READ: state_nxt = tam_pkg::BK_SUM;
      tam_pkg::BK_SUM: begin
        wr_en     = 1'b1;
        div_start = 1'b1;
        state_nxt = tam_pkg::BK_DIV;
      end
      tam_pkg::BK_DIV: begin
        if (div_done) state_nxt = tam_pkg::BK_OUT;
      end
      tam_pkg::BK_OUT: begin
        if (out_ch.ready) state_nxt = tam_pkg::BK_IDLE;
      end
      default: state_nxt = tam_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tam_pkg::BK_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_data;
    if (div_done) begin
      mean_r  <= quot;
      count_r <= tam_pkg::COUNT_W'(job_fill);
    end
  end

  // ring memory: one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) ring[job_ptr] <= job_smp;
    rd_data_r <= ring[job_ptr];
  end

  tam_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (job_fill),
    .done     (div_done),
    .quot     (quot)
  );

  assign out_ch.valid             = (state_r == tam_pkg::BK_OUT);
  assign out_ch.mean_x            = mean_r[0];
  assign out_ch.mean_y            = mean_r[1];
  assign out_ch.mean_z            = mean_r[2];
  assign out_ch.samples_in_window = count_r;

endmodule

FILE: rtl/three_axis_moving_average.sv
// Top level of the three-axis boxcar moving average.
// Depends on tam_pkg, tam_if, tam_front, tam_queue and tam_back.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   sample_x, sample_y, sample_z (s16)        valid/ready
//   out_ch   out  mean_x, mean_y, mean_z (s16), samples (7)  valid/ready
//
// In the back end each sample passes in turn through the ring read, the sum update,
// the bit-serial divider and the result handoff.
// A two-deep job queue lets samples be taken while a result waits on out_ch.
// Reset is synchronous and needs no clearing pass: the fill count masks unwritten slots.
// in_ch.ready drops only when the job queue is full.
module three_axis_moving_average #(
  parameter int WINDOW = 100
) (
  input  logic      clk,
  input  logic      rst_n,
  tam_in_if.sink    in_ch,
  tam_out_if.source out_ch
);

  localparam int PW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = tam_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int JW = tam_pkg::AXES * tam_pkg::SAMPLE_W + PW + CW + 1;

  logic          push, pop, q_full, q_empty;
  logic [JW-1:0] push_data, pop_data;

  tam_front #(
    .WINDOW (WINDOW),
    .PW     (PW),
    .CW     (CW),
    .JW     (JW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tam_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  tam_back #(
    .WINDOW (WINDOW),
    .PW     (PW),
    .CW     (CW),
    .SW     (SW),
    .JW     (JW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/tam_checker.sv
// Port-level checks for the moving average, bound onto the top level.
// Depends on tam_pkg and three_axis_moving_average.
module tam_checker #(
  parameter int WINDOW = 100
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input tam_pkg::sample_t mean_x,
  input tam_pkg::sample_t mean_y,
  input tam_pkg::sample_t mean_z,
  input tam_pkg::count_t  samples
);

  // samples taken but not yet returned
  logic [3:0] pending_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= '0;
    else pending_r <= pending_r + {3'b0, in_fire} - {3'b0, out_fire};
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(mean_x) && $stable(mean_y) && $stable(mean_z)
                                && $stable(samples))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result offered with no sample outstanding");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (WINDOW > 127) || (samples != '0 && 32'(samples) <= WINDOW))
    else $error("samples_in_window out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind three_axis_moving_average tam_checker #(.WINDOW(WINDOW)) u_tam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mean_x    (out_ch.mean_x),
  .mean_y    (out_ch.mean_y),
  .mean_z    (out_ch.mean_z),
  .samples   (out_ch.samples_in_window)
);

FILE: sim/three_axis_moving_average_tb.sv
// Testbench for three_axis_moving_average: valid/ready stimulus, a running-sum
// predictor of the windowed means and an in-order checker of every output transfer.
// Depends on tam_pkg, tam_if and the three_axis_moving_average RTL.
module three_axis_moving_average_tb;

  localparam int WINDOW      = 100;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the job queue
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES = 40;    // extra wait once no result is outstanding

  typedef struct {
    tam_pkg::triple_t means;
    tam_pkg::count_t  count;
  } mean_rec_t;

  // Boxcar predictor: per-axis ring and exact running sums, mean = sum / fill.
  class mean_scoreboard;
    tam_pkg::sample_t window_ring[tam_pkg::AXES][WINDOW];
    longint           axis_sum[tam_pkg::AXES];
    int               wr_ptr;
    int               fill;
    int               errors;
    mean_rec_t        expected_means[$];

    function new();
      foreach (window_ring[a, k]) window_ring[a][k] = '0;
      foreach (axis_sum[a]) axis_sum[a] = 0;
      wr_ptr = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void note_sample(input tam_pkg::triple_t s);
      mean_rec_t r;
      for (int a = 0; a < tam_pkg::AXES; a++) begin
        axis_sum[a] = axis_sum[a] - window_ring[a][wr_ptr] + $signed(s[a]);
        window_ring[a][wr_ptr] = $signed(s[a]);
      end
      wr_ptr = (wr_ptr + 1 == WINDOW) ? 0 : wr_ptr + 1;
      if (fill < WINDOW) fill++;
      // longint division truncates toward zero
      for (int a = 0; a < tam_pkg::AXES; a++)
        r.means[a] = tam_pkg::sample_t'(axis_sum[a] / fill);
      r.count = tam_pkg::count_t'(fill);
      expected_means.push_back(r);
    endfunction

    function void check_mean(input tam_pkg::triple_t m, input tam_pkg::count_t c);
      mean_rec_t r;
      string     axis_name[tam_pkg::AXES];
      axis_name = '{"mean_x", "mean_y", "mean_z"};
      if (expected_means.size() == 0) begin
        $error("unexpected result transfer: mean_x %0d mean_y %0d mean_z %0d count %0d",
               $signed(m[0]), $signed(m[1]), $signed(m[2]), c);
        errors++;
        return;
      end
      r = expected_means.pop_front();
      for (int a = 0; a < tam_pkg::AXES; a++) begin
        if (m[a] !== r.means[a]) begin
          $error("%s: expected %0d, got %0d", axis_name[a], $signed(r.means[a]),
                 $signed(m[a]));
          errors++;
        end
      end
      if (c !== r.count) begin
        $error("samples_in_window: expected %0d, got %0d", r.count, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tam_in_if  in_ch();
  tam_out_if out_ch();

  three_axis_moving_average #(.WINDOW(WINDOW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mean_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go        = 1'b0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample({in_ch.sample_z, in_ch.sample_y, in_ch.sample_x});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_mean({out_ch.mean_z, out_ch.mean_y, out_ch.mean_x}, out_ch.samples_in_window);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("three_axis_moving_average: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(input tam_pkg::sample_t x, input tam_pkg::sample_t y,
                             input tam_pkg::sample_t z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_x <= x;
    in_ch.sample_y <= y;
    in_ch.sample_z <= z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // kinds 4 and 5 pin the axis to an extreme so a full window drives the sums to their limits
  function automatic tam_pkg::sample_t pick_axis(input int kind);
    case (kind)
      3:       return tam_pkg::sample_t'(int'($urandom_range(0, 64)) - 32);
      4:       return 16'sh7FFF;
      5:       return 16'sh8000;
      default: return tam_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int kind;
    int chunk;
    sent = 0;
    while (sent < n_items) begin
      kind  = $urandom_range(0, 5);
      chunk = $urandom_range(10, 130);
      for (int k = 0; k < chunk && sent < n_items; k++) begin
        send_sample(pick_axis(kind), pick_axis(kind), pick_axis(kind));
        sent++;
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window still filling: divisor is the fill count
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0001);
    send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF);
    send_sample(16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_sample(16'sh0001, 16'sh0001, 16'sh0001);
    send_sample(16'sh4000, 16'shC000, 16'sh2000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0003, 16'shFFFD, 16'sh0002);
    send_sample(16'shAAAA, 16'sh5555, 16'sh8001);
    send_sample(16'sh5555, 16'shAAAA, 16'sh7FFE);
    send_sample(16'shFFFE, 16'sh0002, 16'shFFF9);

    run_random(360);
    send_idle_pct = 68;
    run_random(360);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    run_random(360);

    // long hold-off with the sender busy: input must stall until the output drains
    recv_stall_pct = 0;
    @(negedge clk);
    hold_go = 1'b1;
    run_random(60);

    send_idle_pct  = 35;
    recv_stall_pct = 35;
    run_random(360);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_means.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_means.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_means.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("three_axis_moving_average: match");
    end else begin
      $display("three_axis_moving_average: mismatch");
    end
    $finish;
  end

endmodule
